>>> hw/rtl/link_reconnect_backoff_fsm_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the link reconnect backoff unit.
// Each check can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef LINK_RECONNECT_BACKOFF_FSM_UNIT_ASSERT_SVH
`define LINK_RECONNECT_BACKOFF_FSM_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, quiet during reset.
`define LRBF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrbf: assertion failed");
// Next-cycle implication, sampled on clk, quiet during reset.
`define LRBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrbf: assertion failed");
`else
`define LRBF_ASSERT_IMPL(label, ante, cons)
`define LRBF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/lrbf_pkg.sv
// ----------------------------------------------------------------------------
// lrbf_pkg
// Shared types, register codes and reset values of the reconnect unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lrbf_pkg;

  // Widths of the fixed payload fields.
  localparam int unsigned NOW_W       = 32;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned ATTEMPT_W   = 8;
  localparam int unsigned RECONNECT_W = 32;

  // Default time width of stored timestamps.
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // Mode codes as seen on the result word.
  localparam logic [1:0] MODE_DISC         = 2'd0;
  localparam logic [1:0] MODE_CONNECTING   = 2'd1;
  localparam logic [1:0] MODE_CONNECTED    = 2'd2;
  localparam logic [1:0] MODE_RECONNECTING = 2'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONNECT_TIMEOUT  = 8'd0,
    CFG_HEARTBEAT_INTVL  = 8'd1,
    CFG_BASE_BACKOFF     = 8'd2,
    CFG_MAX_BACKOFF      = 8'd3
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] RST_CONNECT_TIMEOUT = 32'd15000;
  localparam logic [CFG_W-1:0] RST_HEARTBEAT_INTVL = 32'd30000;
  localparam logic [CFG_W-1:0] RST_BASE_BACKOFF    = 32'd5000;
  localparam logic [CFG_W-1:0] RST_MAX_BACKOFF     = 32'd120000;

  // Current configuration handed to the step logic.
  typedef struct packed {
    logic [CFG_W-1:0] connect_timeout_ms;
    logic [CFG_W-1:0] heartbeat_interval_ms;
    logic [CFG_W-1:0] base_backoff_ms;
    logic [CFG_W-1:0] backoff_cap_ms;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [1:0]             mode;
    logic                   start_connect;
    logic                   drop_link;
    logic                   connected_event;
    logic                   disconnected_event;
    logic                   heartbeat;
    logic                   link_ok;
    logic [RECONNECT_W-1:0] reconnect_total;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/lrbf_cfg_regs.sv
// ----------------------------------------------------------------------------
// lrbf_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbf_cfg_regs
  import lrbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the index and update the addressed register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.connect_timeout_ms    <= RST_CONNECT_TIMEOUT;
      cfg_r.heartbeat_interval_ms <= RST_HEARTBEAT_INTVL;
      cfg_r.base_backoff_ms       <= RST_BASE_BACKOFF;
      cfg_r.backoff_cap_ms        <= RST_MAX_BACKOFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CONNECT_TIMEOUT: cfg_r.connect_timeout_ms    <= cfg_wdata;
        CFG_HEARTBEAT_INTVL: cfg_r.heartbeat_interval_ms <= cfg_wdata;
        CFG_BASE_BACKOFF:    cfg_r.base_backoff_ms       <= cfg_wdata;
        CFG_MAX_BACKOFF:     cfg_r.backoff_cap_ms        <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lrbf_backoff.sv
// ----------------------------------------------------------------------------
// lrbf_backoff
// Retry wait: base doubled once per failed attempt, capped at the maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbf_backoff
  import lrbf_pkg::*;
(
  input  logic [CFG_W-1:0]     base_ms,
  input  logic [CFG_W-1:0]     max_ms,
  input  logic [ATTEMPT_W-1:0] failed,
  output logic [CFG_W-1:0]     wait_ms
);

  logic [2*CFG_W-1:0] shifted;
  logic               over_range;

  // A shift of 32 or more pushes any nonzero base past every 32-bit cap.
  assign shifted    = {{CFG_W{1'b0}}, base_ms} << failed[4:0];
  assign over_range = (|failed[ATTEMPT_W-1:5]) && (base_ms != '0);

  // Doubling stops at the cap, so the wait is the smaller of the two.
  always_comb begin
    if (over_range) begin
      wait_ms = max_ms;
    end else if (shifted < {{CFG_W{1'b0}}, max_ms}) begin
      wait_ms = shifted[CFG_W-1:0];
    end else begin
      wait_ms = max_ms;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lrbf_step.sv
// ----------------------------------------------------------------------------
// lrbf_step
// Mode state machine and timers; computes the result of one poll and
// commits the new state when the poll moves into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbf_step
  import lrbf_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [NOW_W-1:0] now_ms,
  input  logic             link_up,
  input  cfg_t             cfg,
  output res_t             res
);

  localparam int unsigned CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

  typedef enum logic [1:0] {
    ST_DISC         = MODE_DISC,
    ST_CONNECTING   = MODE_CONNECTING,
    ST_CONNECTED    = MODE_CONNECTED,
    ST_RECONNECTING = MODE_RECONNECTING
  } state_t;

  state_t                 mode_r, mode_nxt;
  logic [TIME_WIDTH-1:0]  phase_start_r, phase_start_nxt;
  logic [TIME_WIDTH-1:0]  last_hb_r, last_hb_nxt;
  logic [ATTEMPT_W-1:0]   failed_r, failed_nxt;
  logic [RECONNECT_W-1:0] reconnect_r, reconnect_nxt;
  logic                   ever_r, ever_nxt;

  logic [TIME_WIDTH-1:0]  now_t;
  logic [TIME_WIDTH-1:0]  phase_elapsed, hb_elapsed;
  logic [CFG_W-1:0]       backoff_ms;
  logic                   start, drop, conn_ev, disc_ev, hb;

  // Time is taken modulo 2^TIME_WIDTH; differences wrap the same way.
  assign now_t         = TIME_WIDTH'(now_ms);
  assign phase_elapsed = now_t - phase_start_r;
  assign hb_elapsed    = now_t - last_hb_r;

  lrbf_backoff u_backoff (
    .base_ms (cfg.base_backoff_ms),
    .max_ms  (cfg.backoff_cap_ms),
    .failed  (failed_r),
    .wait_ms (backoff_ms)
  );

  // Next state and event pulses for the poll in the input register.
  always_comb begin
    mode_nxt        = mode_r;
    phase_start_nxt = phase_start_r;
    last_hb_nxt     = last_hb_r;
    failed_nxt      = failed_r;
    reconnect_nxt   = reconnect_r;
    ever_nxt        = ever_r;
    start           = 1'b0;
    drop            = 1'b0;
    conn_ev         = 1'b0;
    disc_ev         = 1'b0;
    hb              = 1'b0;
    unique case (mode_r)
      ST_DISC: begin
        start           = 1'b1;
        phase_start_nxt = now_t;
        mode_nxt        = ST_CONNECTING;
      end
      ST_CONNECTING: begin
        if (link_up) begin
          mode_nxt   = ST_CONNECTED;
          failed_nxt = '0;
          conn_ev    = 1'b1;
          ever_nxt   = 1'b1;
        end else if (CMP_W'(phase_elapsed) > CMP_W'(cfg.connect_timeout_ms)) begin
          drop            = 1'b1;
          mode_nxt        = ST_RECONNECTING;
          phase_start_nxt = now_t;
          if (failed_r != {ATTEMPT_W{1'b1}}) begin
            failed_nxt = failed_r + ATTEMPT_W'(1);
          end
        end
      end
      ST_CONNECTED: begin
        if (!link_up) begin
          mode_nxt        = ST_RECONNECTING;
          failed_nxt      = '0;
          phase_start_nxt = now_t;
          disc_ev         = ever_r;
          ever_nxt        = 1'b0;
        end else if (CMP_W'(hb_elapsed) >= CMP_W'(cfg.heartbeat_interval_ms)) begin
          last_hb_nxt = now_t;
          hb          = 1'b1;
        end
      end
      ST_RECONNECTING: begin
        if (CMP_W'(phase_elapsed) >= CMP_W'(backoff_ms)) begin
          reconnect_nxt   = reconnect_r + RECONNECT_W'(1);
          start           = 1'b1;
          phase_start_nxt = now_t;
          mode_nxt        = ST_CONNECTING;
        end
      end
      default: ;
    endcase
  end

  // State commits only when the poll moves on to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= ST_DISC;
      phase_start_r <= '0;
      last_hb_r     <= '0;
      failed_r      <= '0;
      reconnect_r   <= '0;
      ever_r        <= 1'b0;
    end else if (adv) begin
      mode_r        <= mode_nxt;
      phase_start_r <= phase_start_nxt;
      last_hb_r     <= last_hb_nxt;
      failed_r      <= failed_nxt;
      reconnect_r   <= reconnect_nxt;
      ever_r        <= ever_nxt;
    end
  end

  // Result word of this poll.
  assign res.mode               = mode_nxt;
  assign res.start_connect      = start;
  assign res.drop_link          = drop;
  assign res.connected_event    = conn_ev;
  assign res.disconnected_event = disc_ev;
  assign res.heartbeat          = hb;
  assign res.link_ok            = link_up && (mode_nxt == ST_CONNECTED);
  assign res.reconnect_total    = reconnect_nxt;

endmodule

`default_nettype wire

>>> hw/rtl/link_reconnect_backoff_fsm_unit.sv
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm_unit
// Pipeline: a poll accepted into the input register passes the step logic
// into the result register, whose fields drive the result ports.
// Throughput: one poll per cycle while out_stall is low; the combinational
// step logic sits between the input register and the result register.
// Reset: synchronous, clears the valid bits of both registers, the mode state and the timers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "link_reconnect_backoff_fsm_unit_assert.svh"

module link_reconnect_backoff_fsm_unit
  import lrbf_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Poll channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [NOW_W-1:0]       in_now_ms,
  input  logic                   in_link_up,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_mode,
  output logic                   out_start_connect,
  output logic                   out_drop_link,
  output logic                   out_connected_event,
  output logic                   out_disconnected_event,
  output logic                   out_heartbeat,
  output logic                   out_link_ok,
  output logic [RECONNECT_W-1:0] out_reconnect_total,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  logic             in_valid_r;
  logic [NOW_W-1:0] in_now_r;
  logic             in_link_up_r;
  logic             out_valid_r;
  res_t             out_res_r;
  res_t             step_res;
  cfg_t             cfg;
  logic             adv;
  logic             in_take;

  // A held poll moves on when the result register is empty or being drained.
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  lrbf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lrbf_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .now_ms  (in_now_r),
    .link_up (in_link_up_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_now_r     <= in_now_ms;
      in_link_up_r <= in_link_up;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_mode               = out_res_r.mode;
  assign out_start_connect      = out_res_r.start_connect;
  assign out_drop_link          = out_res_r.drop_link;
  assign out_connected_event    = out_res_r.connected_event;
  assign out_disconnected_event = out_res_r.disconnected_event;
  assign out_heartbeat          = out_res_r.heartbeat;
  assign out_link_ok            = out_res_r.link_ok;
  assign out_reconnect_total    = out_res_r.reconnect_total;

  // A connect request always leaves the unit in the connecting mode.
  `LRBF_ASSERT_IMPL(a_start_mode, out_valid_r && out_res_r.start_connect,
                    out_res_r.mode == MODE_CONNECTING)
  // A dropped attempt always leads into the backoff wait.
  `LRBF_ASSERT_IMPL(a_drop_mode, out_valid_r && out_res_r.drop_link,
                    out_res_r.mode == MODE_RECONNECTING)
  // Each poll raises at most one event pulse.
  `LRBF_ASSERT_IMPL(a_one_event, out_valid_r,
                    ($onehot0({out_res_r.start_connect, out_res_r.drop_link,
                               out_res_r.connected_event, out_res_r.disconnected_event,
                               out_res_r.heartbeat})))
  // A poll that cannot move on stays in the input register.
  `LRBF_ASSERT_NEXT(a_hold_in, in_valid_r && !adv, in_valid_r)

endmodule

`default_nettype wire

>>> tb/sv/link_reconnect_backoff_fsm_unit_tb.sv
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm_unit_tb
// Self-checking bench for the reconnect controller with exponential backoff.
// Polls are queued by a scenario process and sent by a clocked driver. A
// predictor works out the status word of every accepted poll. A monitor
// checks each status word field by field. The run covers directed sequences,
// several register settings with their extremes, and long random traffic.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_fsm_unit_tb;
  import lrbf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no handshake at all before the run is abandoned.
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct {
    logic [NOW_W-1:0] now_ms;
    logic             link_up;
  } poll_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [NOW_W-1:0]       in_now_ms = '0;
  logic                   in_link_up = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_mode;
  logic                   out_start_connect;
  logic                   out_drop_link;
  logic                   out_connected_event;
  logic                   out_disconnected_event;
  logic                   out_heartbeat;
  logic                   out_link_ok;
  logic [RECONNECT_W-1:0] out_reconnect_total;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  // Polls waiting to be sent and status words waiting to be seen.
  poll_t poll_q[$];
  res_t  expected_status[$];

  int unsigned polls_queued = 0;
  int unsigned polls_taken = 0;
  int unsigned bad_results = 0;
  int unsigned quiet_cycles = 0;
  int unsigned pause_left = 0;
  int unsigned stall_left = 0;
  bit          poll_taken = 1'b0;
  bit          no_idle = 1'b0;

  // Predicted controller state and register copy.
  cfg_t                   model_cfg = '{RST_CONNECT_TIMEOUT, RST_HEARTBEAT_INTVL,
                                        RST_BASE_BACKOFF, RST_MAX_BACKOFF};
  logic [1:0]             link_mode = MODE_DISC;
  logic [NOW_W-1:0]       attempt_start_ms = '0;
  logic [NOW_W-1:0]       heartbeat_ms = '0;
  logic [ATTEMPT_W-1:0]   failures = '0;
  logic [RECONNECT_W-1:0] retries = '0;
  logic                   was_up = 1'b0;

  // Scenario generator state.
  logic [NOW_W-1:0] clock_ms = '0;
  logic             link_level = 1'b0;
  int unsigned      run_left = 0;

  link_reconnect_backoff_fsm_unit u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_now_ms              (in_now_ms),
    .in_link_up             (in_link_up),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_mode               (out_mode),
    .out_start_connect      (out_start_connect),
    .out_drop_link          (out_drop_link),
    .out_connected_event    (out_connected_event),
    .out_disconnected_event (out_disconnected_event),
    .out_heartbeat          (out_heartbeat),
    .out_link_ok            (out_link_ok),
    .out_reconnect_total    (out_reconnect_total),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advances the predicted controller by one poll and returns its status word.
  function automatic res_t step_link(input logic [NOW_W-1:0] now_ms, input logic up);
    res_t             r;
    logic [NOW_W-1:0] since;
    logic [63:0]      retry_ms;
    logic [63:0]      cap_ms;
    int unsigned      n;
    r = '0;
    case (link_mode)
      MODE_DISC: begin
        r.start_connect = 1'b1;
        attempt_start_ms = now_ms;
        link_mode = MODE_CONNECTING;
      end
      MODE_CONNECTING: begin
        since = now_ms - attempt_start_ms;
        if (up) begin
          link_mode = MODE_CONNECTED;
          failures = '0;
          r.connected_event = 1'b1;
          was_up = 1'b1;
        end else if (since > model_cfg.connect_timeout_ms) begin
          r.drop_link = 1'b1;
          link_mode = MODE_RECONNECTING;
          if (failures != '1) begin
            failures = failures + 1'b1;
          end
          attempt_start_ms = now_ms;
        end
      end
      MODE_CONNECTED: begin
        since = now_ms - heartbeat_ms;
        if (!up) begin
          link_mode = MODE_RECONNECTING;
          failures = '0;
          attempt_start_ms = now_ms;
          r.disconnected_event = was_up;
          was_up = 1'b0;
        end else if (since >= model_cfg.heartbeat_interval_ms) begin
          heartbeat_ms = now_ms;
          r.heartbeat = 1'b1;
        end
      end
      default: begin
        // The wait doubles per failure until it reaches the cap; wide math
        // keeps the largest register values from overflowing.
        since = now_ms - attempt_start_ms;
        retry_ms = 64'(model_cfg.base_backoff_ms);
        cap_ms = 64'(model_cfg.backoff_cap_ms);
        for (n = 0; n < failures && retry_ms < cap_ms; n++) begin
          retry_ms = retry_ms << 1;
        end
        if (retry_ms > cap_ms) begin
          retry_ms = cap_ms;
        end
        if (64'(since) >= retry_ms) begin
          retries = retries + 1'b1;
          r.start_connect = 1'b1;
          attempt_start_ms = now_ms;
          link_mode = MODE_CONNECTING;
        end
      end
    endcase
    r.mode = link_mode;
    r.link_ok = up && (link_mode == MODE_CONNECTED);
    r.reconnect_total = retries;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      bad_results++;
    end
  endfunction

  // Length of an idle stretch: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Poll driver: holds a word until it is taken, then maybe idles.
  always @(negedge clk) begin : poll_driver
    poll_t next_poll;
    if (!in_valid || poll_taken) begin
      if (pause_left != 0) begin
        in_valid <= 1'b0;
        pause_left--;
      end else if (poll_q.size() != 0) begin
        next_poll = poll_q.pop_front();
        in_valid <= 1'b1;
        in_now_ms <= next_poll.now_ms;
        in_link_up <= next_poll.link_up;
        pause_left = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin : status_stall
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!no_idle && $urandom_range(0, 99) < 30) begin
        stall_left = idle_len();
      end
    end
  end

  // Monitor: predicts on every taken poll, checks every taken status word.
  always @(posedge clk) begin : status_monitor
    res_t want;
    poll_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (poll_taken) begin
        expected_status.push_back(step_link(in_now_ms, in_link_up));
        polls_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("status word with no poll pending");
          bad_results++;
        end else begin
          want = expected_status.pop_front();
          check_field("mode", want.mode, out_mode);
          check_field("start_connect", want.start_connect, out_start_connect);
          check_field("drop_link", want.drop_link, out_drop_link);
          check_field("connected_event", want.connected_event, out_connected_event);
          check_field("disconnected_event", want.disconnected_event,
                      out_disconnected_event);
          check_field("heartbeat", want.heartbeat, out_heartbeat);
          check_field("link_ok", want.link_ok, out_link_ok);
          check_field("reconnect_total", want.reconnect_total, out_reconnect_total);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONNECT_TIMEOUT: model_cfg.connect_timeout_ms = cfg_wdata;
          CFG_HEARTBEAT_INTVL: model_cfg.heartbeat_interval_ms = cfg_wdata;
          CFG_BASE_BACKOFF:    model_cfg.base_backoff_ms = cfg_wdata;
          CFG_MAX_BACKOFF:     model_cfg.backoff_cap_ms = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Watchdog on handshake activity.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_poll(input logic [NOW_W-1:0] now_ms, input logic up);
    poll_t p;
    p.now_ms = now_ms;
    p.link_up = up;
    poll_q.push_back(p);
    polls_queued++;
  endtask

  // Advancing time with link-up and link-down runs, plus some stray polls.
  task automatic add_traffic(input int unsigned count, input logic [31:0] step_max);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if (run_left == 0) begin
        link_level = !link_level;
        run_left = $urandom_range(1, link_level ? 16 : 8);
      end
      run_left--;
      if ($urandom_range(0, 99) < 5) begin
        add_poll($urandom(), 1'($urandom()));
      end else begin
        if ($urandom_range(0, 99) < 15) begin
          clock_ms += $urandom_range(0, 2);
        end else begin
          clock_ms += $urandom_range(0, step_max);
        end
        add_poll(clock_ms, link_level);
      end
    end
  endtask

  // A long outage: enough failed attempts to pin the attempt counter at its
  // top, then random gaps that tell the capped wait from the base wait.
  task automatic add_outage(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if (k + 30 < count) begin
        clock_ms += $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
      end else begin
        clock_ms += $urandom_range(32'hFFFF_FFFF, 1);
      end
      add_poll(clock_ms, 1'b0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] timeout_ms, input logic [CFG_W-1:0] hb_ms,
                               input logic [CFG_W-1:0] base_ms, input logic [CFG_W-1:0] cap_ms);
    write_reg(CFG_CONNECT_TIMEOUT, timeout_ms);
    write_reg(CFG_HEARTBEAT_INTVL, hb_ms);
    write_reg(CFG_BASE_BACKOFF, base_ms);
    write_reg(CFG_MAX_BACKOFF, cap_ms);
  endtask

  // Holds off until every queued poll is taken and every status word seen.
  task automatic drain_polls();
    while (polls_taken != polls_queued || expected_status.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin : scenario
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk at reset settings: timeout edge, doubling backoff,
    // heartbeat edge across the time wrap, link loss and recovery.
    add_poll(32'd0, 1'b1);
    add_poll(32'd15000, 1'b0);
    add_poll(32'd15001, 1'b0);
    add_poll(32'd25000, 1'b0);
    add_poll(32'd25001, 1'b1);
    add_poll(32'd25002, 1'b1);
    add_poll(32'd29999, 1'b1);
    add_poll(32'd30000, 1'b1);
    add_poll(32'd30001, 1'b1);
    add_poll(32'hFFFF_FFF0, 1'b1);
    add_poll(32'd29984, 1'b1);
    add_poll(32'd29985, 1'b0);
    add_poll(32'd34984, 1'b1);
    add_poll(32'd34985, 1'b1);
    add_poll(32'd49986, 1'b0);
    add_poll(32'd59986, 1'b0);
    add_poll(32'd74987, 1'b0);
    add_poll(32'd94986, 1'b0);
    add_poll(32'd94987, 1'b0);
    add_poll(32'd94988, 1'b1);
    add_poll(32'hFFFF_FFFF, 1'b1);
    add_poll(32'hFFFF_FFFF, 1'b0);
    clock_ms = 32'd100000;
    add_traffic(120, 8000);
    drain_polls();

    // Small settings: timeouts, backoffs and heartbeats come often.
    load_settings(32'd20, 32'd15, 32'd3, 32'd50);
    @(posedge clk);
    add_traffic(150, 12);
    drain_polls();

    // Largest settings, plus a write to an index the block ignores.
    load_settings('1, '1, 32'h8000_0000, 32'h8000_0000);
    write_reg(CFG_IDX_W'($urandom_range(CFG_MAX_BACKOFF + 1, 255)), $urandom());
    @(posedge clk);
    add_traffic(80, 32'hFFFF_FFFF);
    drain_polls();

    // All zero: instant timeouts and retries, a heartbeat on every poll.
    load_settings('0, '0, '0, '0);
    @(posedge clk);
    no_idle = 1'b1;
    add_traffic(100, 3);
    drain_polls();
    no_idle = 1'b0;

    // Long outage with the widest backoff range.
    load_settings('0, 32'd1, 32'd1, 32'h8000_0000);
    @(posedge clk);
    add_outage(560);
    drain_polls();

    // Random small settings.
    repeat (2) begin
      load_settings($urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(1, 20),
                    $urandom_range(1, 200));
      write_reg(CFG_IDX_W'($urandom_range(CFG_MAX_BACKOFF + 1, 255)), $urandom());
      @(posedge clk);
      add_traffic(60, 30);
      drain_polls();
    end

    // Base wait above the cap.
    load_settings(32'd25, 32'd40, 32'd90, 32'd30);
    @(posedge clk);
    add_traffic(40, 40);
    drain_polls();

    repeat (6) @(posedge clk);
    if (bad_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
